[src/rmi_pkg.sv]
package rmi_pkg;

	localparam int CAPACITY  = 64;
	localparam int DATA_W    = 32;
	localparam int MED_W     = DATA_W + 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int OUT_CNT_W = 7;
	localparam int GROUP     = 8;
	localparam int NGRP      = (CAPACITY + GROUP - 1) / GROUP;

	// Stage enables handed from the top level to the median tree.
	typedef struct packed {
		logic grp_en;
		logic sum_en;
	} rmi_tree_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GRP  = 4'b0010,
		ST_SUM  = 4'b0100,
		ST_OUT  = 4'b1000
	} rmi_state_t;

endpackage

[src/rmi_cell.sv]
module rmi_cell
	import rmi_pkg::*;
(
	input  logic                     clk,
	input  logic                     ins_en,
	input  logic signed [DATA_W-1:0] sample,
	input  logic                     occupied,
	input  logic                     tail,
	input  logic                     left_gt,
	input  logic signed [DATA_W-1:0] left_data,
	output logic signed [DATA_W-1:0] data,
	output logic                     gt
);

	logic signed [DATA_W-1:0] data_q;

	// Strictly greater, so an equal sample lands above the stored copies.
	assign gt   = occupied && (data_q > sample);
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ins_en) begin
			if (left_gt) begin
				data_q <= left_data;
			end else if (tail || gt) begin
				data_q <= sample;
			end
		end
	end

endmodule

[src/rmi_tree.sv]
module rmi_tree
	import rmi_pkg::*;
(
	input  logic                     clk,
	input  rmi_tree_ctrl_t           ctrl,
	input  logic signed [DATA_W-1:0] data [CAPACITY],
	input  logic [CNT_W-1:0]         count,
	output logic signed [MED_W-1:0]  median
);

	logic [CNT_W-1:0]  cnt_m1;
	logic [IDX_W-1:0]  lo_idx;
	logic [IDX_W-1:0]  hi_idx;
	logic [DATA_W-1:0] lo_grp [NGRP];
	logic [DATA_W-1:0] hi_grp [NGRP];
	logic [DATA_W-1:0] lo_grp_s1 [NGRP];
	logic [DATA_W-1:0] hi_grp_s1 [NGRP];
	logic [DATA_W-1:0] lo_all;
	logic [DATA_W-1:0] hi_all;
	logic signed [MED_W-1:0] median_q;

	// Lower and upper middle slots; they coincide when the count is odd.
	assign cnt_m1 = count - CNT_W'(1);
	assign lo_idx = IDX_W'(cnt_m1 >> 1);
	assign hi_idx = IDX_W'(count >> 1);

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			lo_grp[g] = '0;
			hi_grp[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < CAPACITY) begin
					if (lo_idx == IDX_W'(g * GROUP + k)) begin
						lo_grp[g] = lo_grp[g] | data[g * GROUP + k];
					end
					if (hi_idx == IDX_W'(g * GROUP + k)) begin
						hi_grp[g] = hi_grp[g] | data[g * GROUP + k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.grp_en) begin
			lo_grp_s1 <= lo_grp;
			hi_grp_s1 <= hi_grp;
		end
	end

	always_comb begin
		lo_all = '0;
		hi_all = '0;
		for (int g = 0; g < NGRP; g++) begin
			lo_all = lo_all | lo_grp_s1[g];
			hi_all = hi_all | hi_grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.sum_en) begin
			median_q <= $signed({lo_all[DATA_W-1], lo_all}) + $signed({hi_all[DATA_W-1], hi_all});
		end
	end

	assign median = median_q;

endmodule

[src/running_median_insertion.sv]
// Running median by insertion. Each request carries one signed 32-bit sample
// and a restart bit; each request yields exactly one result holding twice the
// median of all samples held (the middle entry doubled for an odd count, the
// sum of the two middle entries for an even count), the count held, and an
// overflow flag. The samples live in a row of 64 compare-and-shift cells that
// keep them in ascending order: on the accept edge every value larger than the
// new sample moves up into the next cell and the sample drops into the
// gap, so insertion itself is done on that edge. A sample equal to stored values
// goes above them. Restart empties the store before the sample goes in, so the
// count restarts at one. When the store is full and restart is low, the
// sample is dropped, the store is left as it was, and the result reports the
// existing median and count with overflow set. The result is offered once
// the cell row has been written on the accept edge and the registered
// selection tree has then picked the middle entries (ST_GRP) and added them
// (ST_SUM). One request is in flight at a time; a new request is accepted in
// the same cycle the pending result is taken, and never before it. No
// clearing pass is needed after reset: only entries below the count are ever
// selected.
module running_median_insertion
	import rmi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  logic signed [31:0]       sample,
	input  logic                     restart,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [32:0]       median_doubled,
	output logic [6:0]               sample_count,
	output logic                     overflow
);

	rmi_state_t        state_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [OUT_CNT_W-1:0] cnt_out_q;
	logic              ovf_out_q;

	logic              accept;
	logic              full;
	logic              ins_en;
	logic [CNT_W-1:0]  count_eff;
	rmi_tree_ctrl_t    tree_ctrl;

	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]      cell_gt;

	// A new request is taken when idle, or when the pending result leaves.
	assign sample_ready = (state_q == ST_IDLE) || ((state_q == ST_OUT) && result_ready);
	assign accept       = sample_valid && sample_ready;
	assign full         = (count_q == CNT_W'(CAPACITY));
	assign count_eff    = restart ? '0 : count_q;
	// The cells only move when the sample is actually kept.
	assign ins_en       = accept && (restart || !full);

	// Cell row. Each cell sees whether its lower neighbor holds a value larger
	// than the sample; if so it takes that value, which opens the slot where
	// the sample belongs.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     left_gt;
		logic signed [DATA_W-1:0] left_data;

		if (i == 0) begin : g_first
			assign left_gt   = 1'b0;
			assign left_data = sample;
		end else begin : g_rest
			assign left_gt   = cell_gt[i-1];
			assign left_data = cell_data[i-1];
		end

		rmi_cell u_cell (
			.clk       (clk),
			.ins_en    (ins_en),
			.sample    (sample),
			.occupied  (count_eff > CNT_W'(i)),
			.tail      (count_eff == CNT_W'(i)),
			.left_gt   (left_gt),
			.left_data (left_data),
			.data      (cell_data[i]),
			.gt        (cell_gt[i])
		);
	end

	// Count and overflow are settled on the accept edge, together with the
	// cell row, so the tree below sees a consistent store and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			ovf_q <= !restart && full;
			priority if (restart) begin
				count_q <= CNT_W'(1);
			end else if (!full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_GRP;
				end
				ST_GRP: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (accept) begin
						state_q <= ST_GRP;
					end else if (result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign tree_ctrl.grp_en = (state_q == ST_GRP);
	assign tree_ctrl.sum_en = (state_q == ST_SUM);

	rmi_tree u_tree (
		.clk    (clk),
		.ctrl   (tree_ctrl),
		.data   (cell_data),
		.count  (count_q),
		.median (median_doubled)
	);

	// Count and flag are copied next to the median so that all three result
	// fields change together on the same edge.
	always_ff @(posedge clk) begin
		if (tree_ctrl.sum_en) begin
			cnt_out_q <= OUT_CNT_W'(count_q);
			ovf_out_q <= ovf_q;
		end
	end

	assign result_valid = (state_q == ST_OUT);
	assign sample_count = cnt_out_q;
	assign overflow     = ovf_out_q;

endmodule

[src/rmi_checker.sv]
module rmi_checker
	import rmi_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_ready,
	input logic signed [31:0] sample,
	input logic               restart,
	input logic               result_valid,
	input logic               result_ready,
	input logic signed [32:0] median_doubled,
	input logic [6:0]         sample_count,
	input logic               overflow
);

	// A pending result holds still until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(median_doubled)
		&& $stable(sample_count) && $stable(overflow))
		else $error("pending result changed before it was taken");

	// Only one request is in flight: a new one enters only as the result leaves.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready && result_valid |-> result_ready)
		else $error("request taken while a result is still pending");

	// Every result that appears follows an accepted request.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_valid && sample_ready, 3))
		else $error("result without a matching request");

	// A restart leaves just the new sample in the store.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) && $past(restart, 3) |->
		sample_count == 7'd1 && !overflow && median_doubled == {$past(sample, 3), 1'b0})
		else $error("restart did not leave a single sample");

	// Overflow is only flagged with a full store.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && overflow |-> sample_count == OUT_CNT_W'(CAPACITY))
		else $error("overflow flagged below capacity");

endmodule

bind running_median_insertion rmi_checker u_rmi_checker (.*);

[sim/testbench.sv]
module testbench;
	import rmi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The slowest correct run is set by the pace of the block, random gaps on both
	// sides and one long receiver hold-off. This limit leaves a wide margin above
	// that.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AT       = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int CALM_FIRST    = 600;
	localparam int CALM_LAST     = 800;

	localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;

	// One request: a sample and its restart bit.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     restart;
	} sample_req_t;

	// One expected result, at the widths of the result ports.
	typedef struct packed {
		logic signed [MED_W-1:0] median2;
		logic [OUT_CNT_W-1:0]    count;
		logic                    dropped;
	} median_result_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     sample_valid = 1'b0;
	logic                     sample_ready;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     restart = 1'b0;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	logic signed [MED_W-1:0]  median_doubled;
	logic [OUT_CNT_W-1:0]     sample_count;
	logic                     overflow;

	// Requests waiting to be offered, and medians waiting to come out.
	sample_req_t    pending_reqs[$];
	median_result_t median_due[$];

	// Our own copy of the sorted store. Only entries below held are ever read.
	logic signed [DATA_W-1:0] sorted_vals[CAPACITY];
	int                       held = 0;

	int errors     = 0;
	int sent_count = 0;
	int taken      = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	int cycle_count;

	running_median_insertion i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample        (sample),
		.restart       (restart),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.median_doubled(median_doubled),
		.sample_count  (sample_count),
		.overflow      (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Insert one accepted sample into the sorted copy the way insertion sort does
	// (an equal sample lands above the stored copies) and return the median that
	// the block must report for it, doubled so that it stays an integer.
	function automatic median_result_t insert_and_median(logic signed [DATA_W-1:0] value,
			logic rs);
		median_result_t r;
		int             pos;
		int             half;
		r.dropped = 1'b0;
		if (rs) begin
			held = 0;
		end
		if (held < CAPACITY) begin
			pos = held;
			while (pos > 0 && sorted_vals[pos-1] > value) begin
				sorted_vals[pos] = sorted_vals[pos-1];
				pos--;
			end
			sorted_vals[pos] = value;
			held++;
		end else begin
			// A full store drops the sample and reports the median it already holds.
			r.dropped = 1'b1;
		end
		half = held / 2;
		if (held % 2 == 1) begin
			r.median2 = {sorted_vals[half], 1'b0};
		end else begin
			r.median2 = {sorted_vals[half][DATA_W-1], sorted_vals[half]}
				+ {sorted_vals[half-1][DATA_W-1], sorted_vals[half-1]};
		end
		r.count = held[OUT_CNT_W-1:0];
		return r;
	endfunction

	// Sample values lean toward a narrow band, so that duplicates and ties are
	// common, and toward the extremes, where the doubled median needs its 33rd bit.
	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = $signed($urandom_range(20)) - 10;
			6: begin
				case ($urandom_range(5))
					0: v = S_MIN;
					1: v = S_MAX;
					2: v = 0;
					3: v = -1;
					4: v = S_MIN + 1;
					default: v = S_MAX - 1;
				endcase
			end
			7: v = $urandom_range(1) ? S_MAX - $urandom_range(1000) : S_MIN + $urandom_range(1000);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic void add_req(logic signed [DATA_W-1:0] value, logic rs);
		sample_req_t q;
		q.value   = value;
		q.restart = rs;
		pending_reqs = {pending_reqs, q};
	endfunction

	// Driver. A new request is put up only when the bus is free or the current one
	// is being taken at this edge, so valid and payload hold steady while stalled.
	// The prediction is made at the edge where the handshake completes.
	always @(posedge clk or negedge arst_n) begin
		sample_req_t nxt;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample       <= '0;
			restart      <= 1'b0;
		end else begin
			if (sample_valid && sample_ready) begin
				median_due = {median_due, insert_and_median(sample, restart)};
				sent_count++;
			end
			if (!sample_valid || sample_ready) begin
				if (pending_reqs.size() != 0 &&
						((sent_count >= CALM_FIRST && sent_count < CALM_LAST) ||
						$urandom_range(99) >= 25)) begin
					nxt = pending_reqs.pop_front();
					sample_valid <= 1'b1;
					sample       <= nxt.value;
					restart      <= nxt.restart;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. It checks every result taken against the oldest expected median and
	// drives the receiver's ready, with random gaps, a calm stretch, and a single long
	// hold-off during which the sender keeps offering and the block backs up.
	always @(posedge clk or negedge arst_n) begin
		median_result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				taken++;
				if (median_due.size() == 0) begin
					$error("result with no request pending: median_doubled %0d count %0d",
						median_doubled, sample_count);
					errors++;
				end else begin
					want = median_due.pop_front();
					if (median_doubled !== want.median2) begin
						$error("median_doubled: expected %0d, actual %0d",
							want.median2, median_doubled);
						errors++;
					end
					if (sample_count !== want.count) begin
						$error("sample_count: expected %0d, actual %0d", want.count, sample_count);
						errors++;
					end
					if (overflow !== want.dropped) begin
						$error("overflow: expected %0b, actual %0b", want.dropped, overflow);
						errors++;
					end
				end
			end
			if (!hold_done && taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= (taken >= CALM_FIRST && taken < CALM_LAST) ||
					($urandom_range(99) >= 25);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int seg_len;
		int made;
		// Directed part. The first request goes into the empty store without restart.
		add_req(S_MAX, 1'b0);
		add_req(S_MAX, 1'b0);              // largest doubled median
		add_req(S_MIN, 1'b1);              // restart with the most negative sample
		add_req(S_MIN, 1'b0);              // most negative doubled median
		add_req(S_MAX, 1'b0);
		add_req(S_MAX, 1'b0);              // even count straddling both extremes
		add_req(0, 1'b1);
		add_req(-1, 1'b0);
		add_req(1, 1'b0);
		add_req(-1, 1'b0);                 // duplicate goes above its twin
		add_req(S_MAX, 1'b1);
		add_req(S_MIN, 1'b0);              // sum of the extremes is minus one
		add_req(5, 1'b1);
		add_req(5, 1'b0);
		add_req(5, 1'b0);
		add_req(4, 1'b0);
		add_req(6, 1'b0);
		add_req(32'sh5555_5555, 1'b1);
		add_req(32'shaaaa_aaaa, 1'b0);
		add_req(S_MIN + 1, 1'b0);
		// Random part: runs that each start with a restart. Most runs are short, some
		// fill the store partly, and some overrun it so that full-store drops occur
		// and a later restart empties a full store. Stray restarts inside a run are
		// the noise.
		made = 0;
		while (made < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: seg_len = $urandom_range(12, 1);
				5, 6, 7: seg_len = $urandom_range(63, 13);
				default: seg_len = $urandom_range(90, 64);
			endcase
			for (int i = 0; i < seg_len; i++) begin
				add_req(pick_value(), i == 0 || $urandom_range(49) == 0);
			end
			made += seg_len;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every request offered and taken, every result seen, then a settling wait
		// in case the block produces something it should not. The checks are made
		// on the falling edge, once everything from the rising edge has settled.
		while (pending_reqs.size() != 0 || sample_valid) @(negedge clk);
		while (median_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

endmodule
